FILE: rtl/core/lmlt_pkg.sv
// ----------------------------------------------------------------------------
// LCD mode and line timing package
// Timing constants, field widths, display mode codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lmlt_pkg;

    localparam int CNT_W  = 10;
    localparam int LINE_W = 8;
    localparam int CYC_W  = 8;
    localparam int CFG_W  = 8;
    localparam int IDX_W  = 3;

    localparam logic [CNT_W-1:0]  LINE_CYCLES    = CNT_W'(456);
    localparam logic [CNT_W-1:0]  OAM_BOUND      = CNT_W'(376);
    localparam logic [CNT_W-1:0]  TRANSFER_BOUND = CNT_W'(204);
    localparam logic [LINE_W-1:0] VISIBLE_LINES  = LINE_W'(144);
    localparam logic [LINE_W-1:0] LAST_LINE      = LINE_W'(153);

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DISPLAY_ENABLE    = 3'd0,
        REG_COMPARE_LINE      = 3'd1,
        REG_HBLANK_IRQ_EN     = 3'd2,
        REG_VBLANK_OAM_IRQ_EN = 3'd3,
        REG_COINC_IRQ_EN      = 3'd4
    } reg_index_t;

endpackage

`default_nettype wire

FILE: rtl/core/lcd_mode_and_line_timing.sv
// ----------------------------------------------------------------------------
// LCD mode and line timing
// Per-line countdown, line counter, display mode, status and vblank interrupts.
// ----------------------------------------------------------------------------
// Each accepted input beat's result is registered and valid in the next cycle.
// Throughput: one beat per cycle; the only stall is a held result register.
// Reset: countdown loads the line length, line and mode clear, display on,
//        compare line and interrupt enables clear, no result pending.
`default_nettype none

module lcd_mode_and_line_timing
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_we,
    input  wire logic [lmlt_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [lmlt_pkg::CFG_W-1:0]  cfg_data,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lmlt_pkg::CYC_W-1:0]  elapsed_cycles,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lmlt_pkg::LINE_W-1:0]      current_line,
    output logic [1:0]                       display_mode,
    output logic                             coincidence,
    output logic                             status_irq,
    output logic                             vblank_irq,
    output logic                             line_done,
    output logic [lmlt_pkg::LINE_W-1:0]      done_line
);

    import lmlt_pkg::*;

    logic              display_enable_reg;
    logic [LINE_W-1:0] compare_line_reg;
    logic              hblank_irq_en_reg;
    logic              vblank_oam_irq_en_reg;
    logic              coinc_irq_en_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    mode_t             mode_reg;
    mode_t             mode_next;

    logic              out_valid_reg;
    logic [LINE_W-1:0] cur_line_reg;
    mode_t             disp_mode_reg;
    logic              coinc_reg;
    logic              status_irq_reg;
    logic              vblank_irq_reg;
    logic              line_done_reg;
    logic [LINE_W-1:0] done_line_reg;

    logic              coinc_next;
    logic              status_irq_next;
    logic              vblank_irq_next;
    logic              line_done_next;
    logic [LINE_W-1:0] done_line_next;
    logic              mode_irq_en;
    logic              in_accept;
    logic              out_accept;

    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    always_comb
    begin
        count_next      = count_reg;
        line_next       = line_reg;
        mode_next       = mode_reg;
        coinc_next      = 1'b0;
        status_irq_next = 1'b0;
        vblank_irq_next = 1'b0;
        line_done_next  = 1'b0;
        done_line_next  = '0;
        mode_irq_en     = 1'b0;

        if (!display_enable_reg)
        begin
            count_next = LINE_CYCLES;
            line_next  = '0;
            mode_next  = MODE_OAM;
        end
        else
        begin
            if (line_reg >= VISIBLE_LINES)
            begin
                mode_next   = MODE_VBLANK;
                mode_irq_en = vblank_oam_irq_en_reg;
            end
            else if (count_reg >= OAM_BOUND)
            begin
                mode_next   = MODE_OAM;
                mode_irq_en = vblank_oam_irq_en_reg;
            end
            else if (count_reg >= TRANSFER_BOUND)
            begin
                mode_next   = MODE_TRANSFER;
            end
            else
            begin
                mode_next   = MODE_HBLANK;
                mode_irq_en = hblank_irq_en_reg;
            end

            coinc_next      = (line_reg == compare_line_reg);
            status_irq_next = (mode_irq_en && (mode_next != mode_reg))
                              || (coinc_next && coinc_irq_en_reg);

            if (count_reg > {{(CNT_W-CYC_W){1'b0}}, elapsed_cycles})
            begin
                count_next = count_reg - {{(CNT_W-CYC_W){1'b0}}, elapsed_cycles};
            end
            else
            begin
                count_next = LINE_CYCLES;
                if (line_reg < VISIBLE_LINES)
                begin
                    line_done_next = 1'b1;
                    done_line_next = line_reg;
                end
                else if (line_reg == VISIBLE_LINES)
                begin
                    vblank_irq_next = 1'b1;
                end
                if (line_reg >= LAST_LINE)
                    line_next = '0;
                else
                    line_next = line_reg + LINE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg    <= 1'b1;
            compare_line_reg      <= '0;
            hblank_irq_en_reg     <= 1'b0;
            vblank_oam_irq_en_reg <= 1'b0;
            coinc_irq_en_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DISPLAY_ENABLE:    display_enable_reg    <= cfg_data[0];
                REG_COMPARE_LINE:      compare_line_reg      <= cfg_data[LINE_W-1:0];
                REG_HBLANK_IRQ_EN:     hblank_irq_en_reg     <= cfg_data[0];
                REG_VBLANK_OAM_IRQ_EN: vblank_oam_irq_en_reg <= cfg_data[0];
                REG_COINC_IRQ_EN:      coinc_irq_en_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // advance timing state once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= LINE_CYCLES;
            line_reg      <= '0;
            mode_reg      <= MODE_HBLANK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg <= count_next;
                line_reg  <= line_next;
                mode_reg  <= mode_next;
            end
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_accept)
                out_valid_reg <= 1'b0;
        end
    end

    // hold result beat until taken
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_line_reg   <= line_next;
            disp_mode_reg  <= mode_next;
            coinc_reg      <= coinc_next;
            status_irq_reg <= status_irq_next;
            vblank_irq_reg <= vblank_irq_next;
            line_done_reg  <= line_done_next;
            done_line_reg  <= done_line_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_line = cur_line_reg;
    assign display_mode = disp_mode_reg;
    assign coincidence  = coinc_reg;
    assign status_irq   = status_irq_reg;
    assign vblank_irq   = vblank_irq_reg;
    assign line_done    = line_done_reg;
    assign done_line    = done_line_reg;

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= LAST_LINE)
        else $error("line counter beyond last line");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= LINE_CYCLES))
        else $error("countdown out of range");

    a_disable_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !display_enable_reg)
        |=> (line_reg == '0 && mode_reg == MODE_OAM && count_reg == LINE_CYCLES))
        else $error("disabled display did not reset timing");

    a_done_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_done_reg)
        |-> (done_line_reg < VISIBLE_LINES && !vblank_irq_reg))
        else $error("done line outside visible area");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (out_valid_reg && cur_line_reg == line_reg
                       && disp_mode_reg == mode_reg))
        else $error("result does not match timing state");

endmodule

`default_nettype wire

FILE: test/tb_lcd_mode_and_line_timing.sv
// ----------------------------------------------------------------------------
// LCD mode and line timing testbench
// Drives elapsed-cycle beats into the timing block and checks every result
// beat against a cycle-accurate model of the line countdown, line counter,
// display mode and interrupts. A short table of directed beats and register
// writes comes first, then randomized phases with fresh register settings,
// random gaps on both channels, a long output hold-off and full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lcd_mode_and_line_timing;

    import lmlt_pkg::*;

    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam int PHASES         = 12;
    localparam int PHASE_BEATS    = 84;
    localparam int DARK_BEATS     = 10;
    localparam int DARK_PHASE     = 6;
    localparam int HOLD_PHASE     = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_ROWS  = 22;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        mode_t             mode;
        logic              coinc;
        logic              stat;
        logic              vbl;
        logic              ldone;
        logic [LINE_W-1:0] dline;
    } timing_beat_t;

    typedef enum logic {
        ROW_BEAT  = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        reg_index_t        idx;
        logic [CFG_W-1:0]  val;
        logic              known;
        timing_beat_t      want;
    } step_row_t;

    localparam timing_beat_t NO_EXP =
        '{8'd0, MODE_HBLANK, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0};
    localparam timing_beat_t DARK_EXP =
        '{8'd0, MODE_OAM, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0};

    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd0,   1'b1,
          '{8'd0, MODE_OAM, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0}},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd255, 1'b1,
          '{8'd0, MODE_OAM, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0}},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd255, 1'b1,
          '{8'd1, MODE_HBLANK, 1'b1, 1'b0, 1'b0, 1'b1, 8'd0}},
        '{ROW_WRITE, REG_HBLANK_IRQ_EN,     8'd1,   1'b0, NO_EXP},
        '{ROW_WRITE, REG_VBLANK_OAM_IRQ_EN, 8'd1,   1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd100, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd100, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd100, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd1,   1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd200, 1'b0, NO_EXP},
        '{ROW_WRITE, REG_COMPARE_LINE,      8'd2,   1'b0, NO_EXP},
        '{ROW_WRITE, REG_COINC_IRQ_EN,      8'd1,   1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd0,   1'b0, NO_EXP},
        '{ROW_WRITE, REG_DISPLAY_ENABLE,    8'd0,   1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd255, 1'b1, DARK_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd0,   1'b1, DARK_EXP},
        '{ROW_WRITE, REG_DISPLAY_ENABLE,    8'd1,   1'b0, NO_EXP},
        '{ROW_WRITE, REG_COMPARE_LINE,      8'd255, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd255, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd128, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd127, 1'b0, NO_EXP},
        '{ROW_BEAT,  REG_DISPLAY_ENABLE,    8'd73,  1'b0, NO_EXP}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CYC_W-1:0]     elapsed_cycles;
    logic                 out_valid;
    logic                 out_stall;
    logic [LINE_W-1:0]    current_line;
    logic [1:0]           display_mode;
    logic                 coincidence;
    logic                 status_irq;
    logic                 vblank_irq;
    logic                 line_done;
    logic [LINE_W-1:0]    done_line;

    logic [CNT_W-1:0]     tm_count;
    logic [LINE_W-1:0]    tm_line;
    mode_t                tm_mode;
    logic                 en_display;
    logic [LINE_W-1:0]    en_compare;
    logic                 en_hblank_irq;
    logic                 en_vbl_oam_irq;
    logic                 en_coinc_irq;

    timing_beat_t         pending_timing_q [$];
    logic                 typed_valid;
    timing_beat_t         typed_beat;
    logic                 idle_on;
    logic                 hold_off_req;

    int                   mismatch_cnt;
    int                   beats_in;
    int                   beats_out;
    int                   writes_done;
    int                   vblank_seen;
    int                   status_seen;
    int                   done_seen;
    int                   idle_cycles;

    lcd_mode_and_line_timing uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic timing_beat_t advance_line_timing(input logic [CYC_W-1:0] cyc);
        timing_beat_t r;
        mode_t        nm;
        logic         irq_en;
        r = NO_EXP;
        if (!en_display)
        begin
            tm_count = LINE_CYCLES;
            tm_line  = '0;
            tm_mode  = MODE_OAM;
            return DARK_EXP;
        end
        if (tm_line >= VISIBLE_LINES)
        begin
            nm     = MODE_VBLANK;
            irq_en = en_vbl_oam_irq;
        end
        else if (tm_count >= OAM_BOUND)
        begin
            nm     = MODE_OAM;
            irq_en = en_vbl_oam_irq;
        end
        else if (tm_count >= TRANSFER_BOUND)
        begin
            nm     = MODE_TRANSFER;
            irq_en = 1'b0;
        end
        else
        begin
            nm     = MODE_HBLANK;
            irq_en = en_hblank_irq;
        end
        r.stat  = irq_en && (nm != tm_mode);
        tm_mode = nm;
        r.coinc = (tm_line == en_compare);
        if (r.coinc && en_coinc_irq)
            r.stat = 1'b1;
        if (tm_count > CNT_W'(cyc))
            tm_count = tm_count - CNT_W'(cyc);
        else
        begin
            tm_count = LINE_CYCLES;
            if (tm_line < VISIBLE_LINES)
            begin
                r.ldone = 1'b1;
                r.dline = tm_line;
            end
            else if (tm_line == VISIBLE_LINES)
                r.vbl = 1'b1;
            if (tm_line >= LAST_LINE)
                tm_line = '0;
            else
                tm_line = tm_line + LINE_W'(1);
        end
        r.line = tm_line;
        r.mode = nm;
        return r;
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_DISPLAY_ENABLE:    en_display     = data[0];
            REG_COMPARE_LINE:      en_compare     = data[LINE_W-1:0];
            REG_HBLANK_IRQ_EN:     en_hblank_irq  = data[0];
            REG_VBLANK_OAM_IRQ_EN: en_vbl_oam_irq = data[0];
            REG_COINC_IRQ_EN:      en_coinc_irq   = data[0];
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drive_beat(input logic [CYC_W-1:0] cyc, input logic known,
                              input timing_beat_t want);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        elapsed_cycles <= cyc;
        typed_valid     = known;
        typed_beat      = want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_timing_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall runs, or one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        timing_beat_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = advance_line_timing(elapsed_cycles);
                if (typed_valid)
                    want = typed_beat;
                pending_timing_q.push_back(want);
                beats_in++;
            end
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (vblank_irq)
                    vblank_seen++;
                if (status_irq)
                    status_seen++;
                if (line_done)
                    done_seen++;
                if (pending_timing_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("result beat %0d arrived with nothing pending", beats_out);
                end
                else
                begin
                    want = pending_timing_q.pop_front();
                    if (want.line !== current_line || want.mode !== display_mode
                        || want.coinc !== coincidence || want.stat !== status_irq
                        || want.vbl !== vblank_irq || want.ldone !== line_done
                        || want.dline !== done_line)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                        begin
                            $display("beat %0d exp line=%0d mode=%0d co=%b st=%b vb=%b dn=%b/%0d",
                                     beats_out, want.line, want.mode, want.coinc, want.stat,
                                     want.vbl, want.ldone, want.dline);
                            $display("beat %0d got line=%0d mode=%0d co=%b st=%b vb=%b dn=%b/%0d",
                                     beats_out, current_line, display_mode, coincidence,
                                     status_irq, vblank_irq, line_done, done_line);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         idle_cycles, pending_timing_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int                 i;
        int                 ph;
        int                 n;
        logic [2:0]         irq_bits;
        logic [LINE_W-1:0]  cmp;
        logic [CYC_W-1:0]   cyc;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DISPLAY_ENABLE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        elapsed_cycles = '0;
        typed_valid    = 1'b0;
        typed_beat     = NO_EXP;
        idle_on        = 1'b1;
        hold_off_req   = 1'b0;
        mismatch_cnt   = 0;
        beats_in       = 0;
        beats_out      = 0;
        writes_done    = 0;
        vblank_seen    = 0;
        status_seen    = 0;
        done_seen      = 0;
        idle_cycles    = 0;

        en_display     = 1'b1;
        en_compare     = '0;
        en_hblank_irq  = 1'b0;
        en_vbl_oam_irq = 1'b0;
        en_coinc_irq   = 1'b0;
        tm_count       = LINE_CYCLES;
        tm_line        = '0;
        tm_mode        = MODE_HBLANK;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            end
            else
                drive_beat(DIRECTED[i].val, DIRECTED[i].known, DIRECTED[i].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_reg(REG_DISPLAY_ENABLE, {7'($urandom), 1'(ph != DARK_PHASE)});
            case ($urandom_range(0, 5))
                0:       cmp = 8'd0;
                1:       cmp = 8'd143;
                2:       cmp = 8'd144;
                3:       cmp = 8'd153;
                4:       cmp = 8'd255;
                default: cmp = 8'($urandom_range(0, 153));
            endcase
            write_reg(REG_COMPARE_LINE, cmp);
            irq_bits = (ph == 0) ? 3'b000 : (ph == 1) ? 3'b111 : 3'($urandom);
            write_reg(REG_HBLANK_IRQ_EN,     {7'($urandom), irq_bits[0]});
            write_reg(REG_VBLANK_OAM_IRQ_EN, {7'($urandom), irq_bits[1]});
            write_reg(REG_COINC_IRQ_EN,      {7'($urandom), irq_bits[2]});

            idle_on = (ph % 3) != 2;
            if (ph == HOLD_PHASE)
            begin
                idle_on      = 1'b0;
                hold_off_req = 1'b1;
            end
            n = (ph == DARK_PHASE) ? DARK_BEATS : PHASE_BEATS;
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: cyc = 8'($urandom_range(0, 255));
                    8:       cyc = 8'($urandom_range(0, 15));
                    9:       cyc = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: cyc = 8'($urandom_range(200, 255));
                endcase
                drive_beat(cyc, 1'b0, NO_EXP);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d beats in, %0d beats out, %0d register writes over %0d phases",
                 beats_in, beats_out, writes_done, PHASES);
        $display("saw %0d finished lines, %0d vblank entries, %0d status interrupts",
                 done_seen, vblank_seen, status_seen);
        if (mismatch_cnt == 0 && pending_timing_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
